>>> design/lax_pkg.sv
// ----------------------------------------------------------------------------
// lax_pkg
// Shared types and constants for the 2-D advection grid block.
// ----------------------------------------------------------------------------
package lax_pkg;

    // input beat actions
    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_STEP = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;
    localparam logic [1:0] ACT_NOP  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_GRID_SIZE = 2'd0;
    localparam logic [1:0] CFG_COEF_U    = 2'd1;
    localparam logic [1:0] CFG_COEF_V    = 2'd2;

    localparam logic [6:0] GRID_SIZE_RST = 7'd64;
    localparam int         MIN_N         = 3;
    localparam int         RND_HALF      = 32768;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ST_RD,
        S_ST_LAST,
        S_ST_MUL,
        S_ST_WR,
        S_CP_RD,
        S_CP_WR,
        S_RD_WAIT
    } t_state;

endpackage

>>> design/lax_advection_grid_step.sv
// ----------------------------------------------------------------------------
// lax_advection_grid_step
// Periodic n x n Q15.16 advection grid with stencil time step.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one action per beat:
//   load  - writes one cell of the current grid.
//   read  - the cell goes into the RAM read register, then into an output
//           register once that is free, and waits there while the receiver stalls.
//   step  - advances one time step. Each cell runs four neighbor reads
//           through the single grid RAM read port, a capture of the last
//           read, multiply and write; then an edge copy-over pass reads each
//           cell and writes it back if it is a border cell.
// o_in_stall is high while an action is in progress. A new beat is taken
// while a read result still sits in the output register; a second read then
// waits until that result is taken.
// Output channel (o_out_valid / i_out_stall) holds the result while stalled.
// Config writes (i_cfg_valid / o_cfg_ready) are always accepted.
// Reset clears the control state, the bank select, the sticky saturation
// flag and the registers (grid size 64, coefficients 0). Grid contents are
// undefined until loaded; no clearing pass is run.
// ----------------------------------------------------------------------------
module lax_advection_grid_step
    import lax_pkg::*;
#(
    parameter int MAX_N = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [17:0]        i_cfg_data,
    // input beats
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic [5:0]         i_row,
    input  logic [5:0]         i_col,
    input  logic signed [31:0] i_cell_in,
    // result beats
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_cell_out,
    output logic               o_saturated_seen
);

    localparam int AW    = (MAX_N > 1) ? $clog2(MAX_N) : 1;
    localparam int NW    = $clog2(MAX_N + 1);
    localparam int CW    = (NW > 7) ? NW : 7;
    localparam int RW    = (NW > 6) ? NW : 6;
    localparam int MA    = 1 + 2 * AW;
    localparam int DEPTH = 1 << MA;

    // grid RAM, both banks; address = {bank, row, col}
    logic [31:0]        r_mem [DEPTH];
    logic [31:0]        r_rdata;
    logic [MA-1:0]      w_raddr;
    logic [MA-1:0]      w_waddr;
    logic [31:0]        w_wdata;
    logic               w_we;

    t_state             r_state, n_state;
    logic [6:0]         r_grid_size;
    logic signed [17:0] r_coef_u, r_coef_v;
    logic               r_cur_b;
    logic               r_sat;
    logic [AW-1:0]      r_i, r_j;
    logic [1:0]         r_k;
    logic               r_rd_ok;
    logic signed [31:0] r_a, r_b, r_c, r_d;
    logic signed [47:0] r_sum;
    logic signed [50:0] r_pu, r_pv;
    logic               r_out_valid;
    logic signed [31:0] r_out_data;
    logic               r_out_sat;

    logic [CW-1:0]      w_gsz;
    logic [NW-1:0]      w_n;
    logic [AW-1:0]      w_last;
    logic               w_in_acc;
    logic               w_in_range;
    logic               w_last_cell;
    logic               w_out_free;
    logic [AW-1:0]      w_im, w_ip, w_jm, w_jp;
    logic               w_cp_border;
    logic [AW-1:0]      w_cp_r, w_cp_c;
    logic signed [33:0] w_sum4;
    logic signed [32:0] w_du, w_dv;
    logic signed [50:0] w_pu, w_pv;
    logic signed [52:0] w_t;
    logic signed [36:0] w_q;
    logic               w_ovf;
    logic [31:0]        w_res;

    // effective grid size, clamped to 3..MAX_N
    assign w_gsz = CW'(r_grid_size);
    always_comb begin
        if (w_gsz < CW'(MIN_N)) begin
            w_n = NW'(MIN_N);
        end else if (w_gsz > CW'(MAX_N)) begin
            w_n = NW'(MAX_N);
        end else begin
            w_n = NW'(w_gsz);
        end
    end
    assign w_last = AW'(w_n - NW'(1));

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_in_range  = (RW'(i_row) < RW'(w_n)) && (RW'(i_col) < RW'(w_n));
    assign w_last_cell = (r_i == w_last) && (r_j == w_last);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // periodic neighbors
    assign w_im = (r_i == '0)     ? w_last : r_i - AW'(1);
    assign w_ip = (r_i == w_last) ? '0     : r_i + AW'(1);
    assign w_jm = (r_j == '0)     ? w_last : r_j - AW'(1);
    assign w_jp = (r_j == w_last) ? '0     : r_j + AW'(1);

    // edge copy-over: column rule overrides row rule on the same cell
    always_comb begin
        w_cp_border = 1'b1;
        w_cp_r      = r_i;
        w_cp_c      = r_j;
        if (r_j == '0) begin
            w_cp_c = w_last;
        end else if (r_j == w_last) begin
            w_cp_c = '0;
        end else if (r_i == '0) begin
            w_cp_r = w_last;
        end else if (r_i == w_last) begin
            w_cp_r = '0;
        end else begin
            w_cp_border = 1'b0;
        end
    end

    // stencil arithmetic
    assign w_sum4 = 34'(r_a) + 34'(r_b) + 34'(r_c) + 34'(r_d);
    assign w_du   = 33'(r_b) - 33'(r_a);
    assign w_dv   = 33'(r_d) - 33'(r_c);
    assign w_pu   = 51'(r_coef_u) * 51'(w_du);
    assign w_pv   = 51'(r_coef_v) * 51'(w_dv);
    assign w_t    = 53'(r_sum) - 53'(r_pu) - 53'(r_pv) + 53'(RND_HALF);
    assign w_q    = w_t[52:16];
    assign w_ovf  = !((&w_q[36:31]) || !(|w_q[36:31]));
    assign w_res  = w_ovf ? (w_q[36] ? 32'h8000_0000 : 32'h7fff_ffff) : w_q[31:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    case (i_action)
                        ACT_STEP: n_state = S_ST_RD;
                        ACT_READ: n_state = S_RD_WAIT;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_ST_RD:   n_state = (r_k == 2'd3) ? S_ST_LAST : S_ST_RD;
            S_ST_LAST: n_state = S_ST_MUL;
            S_ST_MUL:  n_state = S_ST_WR;
            S_ST_WR:   n_state = w_last_cell ? S_CP_RD : S_ST_RD;
            S_CP_RD: begin
                if (w_cp_border) begin
                    n_state = S_CP_WR;
                end else if (w_last_cell) begin
                    n_state = S_IDLE;
                end
            end
            S_CP_WR:   n_state = w_last_cell ? S_IDLE : S_CP_RD;
            S_RD_WAIT: n_state = w_out_free ? S_IDLE : S_RD_WAIT;
            default:   n_state = S_IDLE;
        endcase
    end

    // RAM port control
    always_comb begin
        w_raddr = '0;
        w_we    = 1'b0;
        w_waddr = {~r_cur_b, r_i, r_j};
        w_wdata = w_res;
        case (r_state)
            S_IDLE: begin
                w_raddr = {r_cur_b, AW'(i_row), AW'(i_col)};
                w_waddr = {r_cur_b, AW'(i_row), AW'(i_col)};
                w_wdata = i_cell_in;
                w_we    = w_in_acc && (i_action == ACT_LOAD) && w_in_range;
            end
            S_ST_RD: begin
                case (r_k)
                    2'd0:    w_raddr = {r_cur_b, w_im, r_j};
                    2'd1:    w_raddr = {r_cur_b, w_ip, r_j};
                    2'd2:    w_raddr = {r_cur_b, r_i, w_jm};
                    default: w_raddr = {r_cur_b, r_i, w_jp};
                endcase
            end
            S_ST_WR: begin
                w_we = 1'b1;
            end
            S_CP_RD: begin
                w_raddr = {~r_cur_b, w_cp_r, w_cp_c};
            end
            S_CP_WR: begin
                w_we    = 1'b1;
                w_wdata = r_rdata;
            end
            S_RD_WAIT: begin
                w_raddr = {r_cur_b, r_i, r_j};
            end
            default: w_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_grid_size <= GRID_SIZE_RST;
            r_coef_u    <= '0;
            r_coef_v    <= '0;
            r_cur_b     <= 1'b0;
            r_sat       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_GRID_SIZE: r_grid_size <= i_cfg_data[6:0];
                    CFG_COEF_U:    r_coef_u    <= $signed(i_cfg_data);
                    CFG_COEF_V:    r_coef_v    <= $signed(i_cfg_data);
                    default:       ;
                endcase
            end
            if (r_state == S_ST_WR && w_ovf) begin
                r_sat <= 1'b1;
            end
            if ((r_state == S_CP_RD && !w_cp_border && w_last_cell) ||
                (r_state == S_CP_WR && w_last_cell)) begin
                r_cur_b <= ~r_cur_b;
            end
            if (r_state == S_RD_WAIT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath and sweep counters
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_i <= AW'(i_row);
                r_j <= AW'(i_col);
                r_k <= '0;
                if (w_in_acc && i_action == ACT_STEP) begin
                    r_i <= '0;
                    r_j <= '0;
                end
                r_rd_ok <= w_in_range;
            end
            S_ST_RD: begin
                r_k <= r_k + 2'd1;
                if (r_k != 2'd0) begin
                    r_a <= r_b;
                    r_b <= r_c;
                    r_c <= r_d;
                    r_d <= $signed(r_rdata);
                end
            end
            S_ST_LAST: begin
                r_a <= r_b;
                r_b <= r_c;
                r_c <= r_d;
                r_d <= $signed(r_rdata);
            end
            S_ST_MUL: begin
                r_sum <= {w_sum4, 14'd0};
                r_pu  <= w_pu;
                r_pv  <= w_pv;
            end
            S_ST_WR, S_CP_WR: begin
                r_k <= '0;
                if (r_j == w_last) begin
                    r_j <= '0;
                    r_i <= (r_i == w_last) ? '0 : r_i + AW'(1);
                end else begin
                    r_j <= r_j + AW'(1);
                end
            end
            S_CP_RD: begin
                if (!w_cp_border) begin
                    if (r_j == w_last) begin
                        r_j <= '0;
                        r_i <= (r_i == w_last) ? '0 : r_i + AW'(1);
                    end else begin
                        r_j <= r_j + AW'(1);
                    end
                end
            end
            S_RD_WAIT: begin
                if (w_out_free) begin
                    r_out_data <= r_rd_ok ? $signed(r_rdata) : '0;
                    // flag as of the read, held while the beat is stalled
                    r_out_sat  <= r_sat;
                end
            end
            default: r_k <= '0;
        endcase
    end

    assign o_cfg_ready      = 1'b1;
    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_cell_out       = r_out_data;
    assign o_saturated_seen = r_out_sat;

endmodule

>>> sim/tb_lax_advection_grid_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lax_advection_grid_step
// Self-checking bench for the periodic Q15.16 advection grid. A shadow copy
// of both grid banks, the bank select, the sticky saturation flag and the
// three registers is advanced on every accepted input beat. Each read result
// is compared with the oldest pending read. Directed beats cover the corners
// first. Random phases follow under three idling mixes, then a grid size
// above the maximum and a long receiver hold-off.
// ----------------------------------------------------------------------------

class advection_shadow #(int GRID_MAX = 64);

    localparam longint QUARTER = 16384;          // 0.25 of a Q16 sum, in Q32
    localparam longint SAT_HI  = 64'sh7FFF_FFFF;
    localparam longint SAT_LO  = -64'sh8000_0000;

    typedef struct packed {
        logic signed [31:0] value;
        logic               sat;
    } t_read;

    logic signed [31:0] cells  [2][GRID_MAX*GRID_MAX];
    bit                 loaded [2][GRID_MAX*GRID_MAX];
    bit                 bank;
    bit                 sat;
    logic [6:0]         size_reg;
    logic signed [17:0] coef_u;
    logic signed [17:0] coef_v;
    t_read              reads_due[$];

    function new();
        bank     = 1'b0;
        sat      = 1'b0;
        size_reg = lax_pkg::GRID_SIZE_RST;
        coef_u   = '0;
        coef_v   = '0;
    endfunction

    function int eff_size();
        if (int'(size_reg) < lax_pkg::MIN_N) return lax_pkg::MIN_N;
        if (int'(size_reg) > GRID_MAX) return GRID_MAX;
        return int'(size_reg);
    endfunction

    function void set_reg(logic [1:0] idx, logic [17:0] data);
        case (idx)
            lax_pkg::CFG_GRID_SIZE: size_reg = data[6:0];
            lax_pkg::CFG_COEF_U:    coef_u   = data;
            lax_pkg::CFG_COEF_V:    coef_v   = data;
            default: ;
        endcase
    endfunction

    // finds a cell of the live n x n area whose loaded state matches want
    function bit pick_cell(bit want, output int r, output int c);
        int n, start, k, m;
        n     = eff_size();
        start = int'($urandom_range(0, n*n - 1));
        r     = 0;
        c     = 0;
        for (m = 0; m < n*n; m++) begin
            k = (start + m) % (n*n);
            if (loaded[bank][(k / n)*GRID_MAX + (k % n)] == want) begin
                r = k / n;
                c = k % n;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function void advance_grid();
        int     n, i, j, up, dn, lf, rt, k;
        bit     src, dst;
        longint a, b, c, d, t, q, cu, cv;
        n   = eff_size();
        src = bank;
        dst = ~bank;
        cu  = coef_u;
        cv  = coef_v;
        for (i = 0; i < n; i++) begin
            for (j = 0; j < n; j++) begin
                up = (i == 0) ? n - 1 : i - 1;
                dn = (i == n - 1) ? 0 : i + 1;
                lf = (j == 0) ? n - 1 : j - 1;
                rt = (j == n - 1) ? 0 : j + 1;
                a  = cells[src][up*GRID_MAX + j];
                b  = cells[src][dn*GRID_MAX + j];
                c  = cells[src][i*GRID_MAX + lf];
                d  = cells[src][i*GRID_MAX + rt];
                t  = (a + b + c + d) * QUARTER - (cu * (b - a) + cv * (d - c));
                q  = (t + longint'(lax_pkg::RND_HALF)) >>> 16;
                if (q > SAT_HI) begin
                    q   = SAT_HI;
                    sat = 1'b1;
                end
                if (q < SAT_LO) begin
                    q   = SAT_LO;
                    sat = 1'b1;
                end
                cells[dst][i*GRID_MAX + j]  = q[31:0];
                loaded[dst][i*GRID_MAX + j] = 1'b1;
            end
        end
        // edge copy-over, strictly row-major, later writes see earlier ones
        for (i = 0; i < n; i++) begin
            for (j = 0; j < n; j++) begin
                k = i*GRID_MAX + j;
                if (i == 0)     cells[dst][k] = cells[dst][(n - 1)*GRID_MAX + j];
                if (i == n - 1) cells[dst][k] = cells[dst][j];
                if (j == 0)     cells[dst][k] = cells[dst][i*GRID_MAX + n - 1];
                if (j == n - 1) cells[dst][k] = cells[dst][i*GRID_MAX];
            end
        end
        bank = dst;
    endfunction

    function void note_beat(logic [1:0] act, logic [5:0] r, logic [5:0] c,
                            logic [31:0] v);
        int    n, k;
        bit    inside_grid;
        t_read e;
        n           = eff_size();
        k           = int'(r)*GRID_MAX + int'(c);
        inside_grid = (int'(r) < n) && (int'(c) < n);
        case (act)
            lax_pkg::ACT_LOAD: begin
                if (inside_grid) begin
                    cells[bank][k]  = v;
                    loaded[bank][k] = 1'b1;
                end
            end
            lax_pkg::ACT_STEP: advance_grid();
            lax_pkg::ACT_READ: begin
                e.value = inside_grid ? cells[bank][k] : '0;
                e.sat   = sat;
                reads_due.push_back(e);
            end
            default: ;
        endcase
    endfunction

    function int pending();
        return reads_due.size();
    endfunction

    // empty string when the beat matches the oldest pending read
    function string check_read(logic signed [31:0] got_cell, logic got_sat);
        t_read e;
        string msg;
        if (reads_due.size() == 0)
            return $sformatf(" unexpected result cell_out %h saturated_seen %b",
                             got_cell, got_sat);
        e   = reads_due.pop_front();
        msg = "";
        if (got_cell !== e.value)
            msg = {msg, $sformatf(" cell_out %h want %h", got_cell, e.value)};
        if (got_sat !== e.sat)
            msg = {msg, $sformatf(" saturated_seen %b want %b", got_sat, e.sat)};
        return msg;
    endfunction

endclass

module tb_lax_advection_grid_step;
    import lax_pkg::*;

    localparam int          GRID_MAX       = 64;
    localparam int          CYCLE_LIMIT    = 2000000;
    localparam int          LONG_HOLD      = 400;
    localparam int          PHASE_BATCHES  = 3;
    localparam int          PHASE_BEATS    = 7;
    localparam logic [1:0]  CFG_UNUSED     = 2'd3;
    localparam logic [17:0] COEF_ONE       = 18'h10000;
    localparam logic [17:0] COEF_MINUS_ONE = 18'h30000;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index;
    logic [17:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [1:0]         i_action;
    logic [5:0]         i_row;
    logic [5:0]         i_col;
    logic signed [31:0] i_cell_in;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_cell_out;
    logic               o_saturated_seen;

    advection_shadow #(GRID_MAX) sb;

    int          errors        = 0;
    int          cycle_count   = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_req      = 0;
    int          hold_seen     = 0;
    int          hold_left     = 0;
    string       result_msg;
    logic [1:0]  cfg_idx_q[$];
    logic [17:0] cfg_dat_q[$];

    lax_advection_grid_step #(
        .MAX_N(GRID_MAX)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_row           (i_row),
        .i_col           (i_col),
        .i_cell_in       (i_cell_in),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_cell_out      (o_cell_out),
        .o_saturated_seen(o_saturated_seen)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("lax_advection_grid_step regression: fail");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        errors++;
        $display("mismatch at cycle %0d:%s", cycle_count, what);
    endtask

    // result side: check accepted beats, then pick next cycle's stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                result_msg = sb.check_read(o_cell_out, o_saturated_seen);
                if (result_msg != "") report_mismatch(result_msg);
            end
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= (int'($urandom_range(0, 99)) < recv_idle_pct);
            end
        end
    end

    function automatic logic [31:0] rand_cell();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0:       v = $urandom();
            1:       v = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: v = 32'($urandom_range(0, 32'h7F_FFFF)) - 32'h40_0000;
        endcase
        return v;
    endfunction

    function automatic logic [17:0] rand_coef();
        case ($urandom_range(0, 4))
            0:       return COEF_ONE;
            1:       return COEF_MINUS_ONE;
            2:       return '0;
            default: return 18'(int'($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    // mostly small grids; sizes below 3 and of 64 or more now and then
    function automatic logic [6:0] rand_size();
        case ($urandom_range(0, 9))
            0:       return 7'($urandom_range(0, 2));
            1:       return 7'($urandom_range(64, 127));
            default: return 7'($urandom_range(3, 8));
        endcase
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [5:0] r,
                             input logic [5:0] c, input logic [31:0] v);
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_row      <= r;
        i_col      <= c;
        i_cell_in  <= v;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_beat(act, r, c, v);
        if (int'($urandom_range(0, 99)) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic queue_reg(input logic [1:0] idx, input logic [17:0] data);
        cfg_idx_q.push_back(idx);
        cfg_dat_q.push_back(data);
    endtask

    task automatic write_regs();
        logic [1:0]  idx;
        logic [17:0] dat;
        while (cfg_idx_q.size() != 0) begin
            idx = cfg_idx_q.pop_front();
            dat = cfg_dat_q.pop_front();
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= dat;
            do @(posedge i_clk); while (!o_cfg_ready);
            sb.set_reg(idx, dat);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [6:0] size, input logic [17:0] cu,
                             input logic [17:0] cv);
        queue_reg(CFG_GRID_SIZE, {11'd0, size});
        queue_reg(CFG_COEF_U, cu);
        queue_reg(CFG_COEF_V, cv);
        write_regs();
    endtask

    // drain reads, then give a trailing step time to finish
    task automatic settle();
        int n;
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        n = sb.eff_size();
        repeat (8*n*n + 4*n + 16) @(posedge i_clk);
    endtask

    task automatic gen_random_item();
        int n, roll, r, c;
        n    = sb.eff_size();
        roll = int'($urandom_range(0, 99));
        if (roll < 8) begin
            case ($urandom_range(0, 2))
                0: send_item(ACT_NOP, 6'($urandom()), 6'($urandom()), $urandom());
                1: begin
                    if (n < GRID_MAX)
                        send_item(ACT_LOAD, 6'($urandom_range(n, GRID_MAX - 1)),
                                  6'($urandom()), rand_cell());
                    else
                        send_item(ACT_NOP, 6'($urandom()), 6'($urandom()), $urandom());
                end
                default: begin
                    if (n < GRID_MAX)
                        send_item(ACT_READ, 6'($urandom()),
                                  6'($urandom_range(n, GRID_MAX - 1)), rand_cell());
                end
            endcase
        end else if (roll >= 40 && roll < 72 && sb.pick_cell(1'b1, r, c)) begin
            send_item(ACT_READ, 6'(r), 6'(c), rand_cell());
        end else if (roll >= 72 && !sb.pick_cell(1'b0, r, c)) begin
            send_item(ACT_STEP, 6'($urandom()), 6'($urandom()), $urandom());
        end else begin
            // fill holes first so that steps become legal
            if (!sb.pick_cell(1'b0, r, c)) begin
                r = int'($urandom_range(0, n - 1));
                c = int'($urandom_range(0, n - 1));
            end
            send_item(ACT_LOAD, 6'(r), 6'(c), rand_cell());
        end
    endtask

    initial begin : main
        int k, m, b, r, c;
        logic [31:0] v;
        sb = new();
        i_rst_n     <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_action    <= ACT_NOP;
        i_row       <= '0;
        i_col       <= '0;
        i_cell_in   <= '0;
        i_out_stall <= 1'b0;
        send_idle_pct = 27;
        recv_idle_pct = 62;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset grid size is 64: far corner is addressable
        send_item(ACT_LOAD, 6'd63, 6'd63, 32'h7FFF_FFFF);
        send_item(ACT_READ, 6'd63, 6'd63, '0);
        settle();
        configure(7'd3, '0, '0);
        for (k = 0; k < 9; k++) begin
            v = 32'((k + 1) << 16);
            if (k % 2 == 1) v = -v;
            send_item(ACT_LOAD, 6'(k / 3), 6'(k % 3), v);
        end
        send_item(ACT_LOAD, 6'd3, 6'd0, 32'h1234_5678);   // outside grid, dropped
        send_item(ACT_READ, 6'd0, 6'd3, '0);              // outside grid, reads 0
        send_item(ACT_NOP, 6'h3F, 6'h3F, 32'hFFFF_FFFF);
        send_item(ACT_STEP, '0, '0, '0);
        send_item(ACT_READ, 6'd1, 6'd1, '0);
        send_item(ACT_READ, 6'd0, 6'd0, '0);
        settle();
        configure(7'd0, COEF_ONE, COEF_MINUS_ONE);        // size 0 acts as 3
        send_item(ACT_STEP, '0, '0, '0);
        send_item(ACT_READ, 6'd2, 6'd2, '0);
        // opposite extremes on row neighbors force saturation
        send_item(ACT_LOAD, 6'd0, 6'd0, 32'h7FFF_FFFF);
        send_item(ACT_LOAD, 6'd2, 6'd0, 32'h8000_0000);
        send_item(ACT_STEP, '0, '0, '0);
        send_item(ACT_READ, 6'd1, 6'd0, '0);
        send_item(ACT_READ, 6'd0, 6'd0, '0);
        settle();
        queue_reg(CFG_UNUSED, 18'($urandom()));
        write_regs();
        send_item(ACT_READ, 6'd2, 6'd1, '0);

        for (m = 0; m < 3; m++) begin
            send_idle_pct = (m == 0) ? 27 : (m == 1) ? 62 : 0;
            recv_idle_pct = (m == 0) ? 62 : (m == 1) ? 27 : 0;
            for (b = 0; b < PHASE_BATCHES; b++) begin
                settle();
                configure(rand_size(), rand_coef(), rand_coef());
                for (k = 0; k < PHASE_BEATS; k++) gen_random_item();
            end
        end

        // size 127 acts as 64: far corners are live
        settle();
        configure(7'h7F, rand_coef(), rand_coef());
        send_item(ACT_LOAD, 6'd63, 6'd0, rand_cell());
        send_item(ACT_LOAD, 6'd0, 6'd63, rand_cell());
        send_item(ACT_READ, 6'd63, 6'd0, '0);
        send_item(ACT_READ, 6'd0, 6'd63, '0);

        // receiver holds off while reads keep coming: input must stall
        hold_req++;
        for (k = 0; k < 8; k++) begin
            void'(sb.pick_cell(1'b1, r, c));
            send_item(ACT_READ, 6'(r), 6'(c), rand_cell());
        end

        settle();
        if (errors == 0)
            $display("lax_advection_grid_step regression: pass");
        else
            $display("lax_advection_grid_step regression: fail");
        $finish;
    end

endmodule
